/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ffg_pkg.sv */
// ----------------------------------------------------------------------------
// ffg_pkg
// Types, constants and helper functions of the fire flicker generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffg_pkg;

  // Defaults of the top level parameters.
  localparam int unsigned FRAME_MS_DEF        = 33;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  // Configuration register indexes.
  localparam logic [1:0] REG_INTENSITY = 2'd0;
  localparam logic [1:0] REG_SPEED     = 2'd1;
  localparam logic [1:0] REG_ENABLE    = 2'd2;
  localparam logic [1:0] REG_PAUSE     = 2'd3;

  localparam logic [6:0] INTENSITY_RST = 7'd70;
  localparam logic [3:0] SPEED_RST     = 4'd5;
  localparam logic [6:0] INTENSITY_MAX = 7'd100;
  localparam logic [3:0] SPEED_MIN     = 4'd1;
  localparam logic [3:0] SPEED_MAX     = 4'd10;

  // Q32 turn fraction per phase unit for the harmonics 1, 2.3 and 4.7.
  localparam logic [31:0] ANGLE_K1  = 32'd6835653;
  localparam logic [31:0] ANGLE_K23 = 32'd15722001;
  localparam logic [31:0] ANGLE_K47 = 32'd32127568;

  // Odd polynomial of the quarter-wave sine, Q30.
  localparam logic [31:0] SIN_A1 = 32'd1686629713;
  localparam logic [31:0] SIN_A3 = 32'd693598669;
  localparam logic [31:0] SIN_A5 = 32'd85569306;
  localparam logic [31:0] SIN_A7 = 32'd5026994;
  localparam logic [31:0] SIN_A9 = 32'd172272;

  // Harmonic weights 0.5, 0.3 and 0.2 in Q16.
  localparam logic [31:0] WEIGHT_1  = 32'd32768;
  localparam logic [31:0] WEIGHT_23 = 32'd19661;
  localparam logic [31:0] WEIGHT_47 = 32'd13107;

  // ceil(2^32 / 200): exact floor division for dividends below 2^23.
  localparam logic [31:0] RECIP_200 = 32'd21474837;

  localparam logic [31:0] GREEN_SCALE  = 32'd100;
  localparam logic [7:0]  GREEN_BASE   = 8'd80;
  localparam logic [31:0] BRIGHT_SCALE = 32'd70;
  localparam logic [16:0] FACTOR_HALF  = 17'd32768;
  localparam logic [16:0] FACTOR_MIN   = 17'd19661;
  localparam logic [16:0] FACTOR_MAX   = 17'd65536;
  localparam logic [16:0] FLICKER_MAX  = 17'd65536;

  localparam logic [7:0] RED_LEVEL  = 8'd255;
  localparam logic       BLUE_LEVEL = 1'b0;

  localparam logic [1:0] HARM_LAST = 2'd2;

  // Datapath operations, one per cycle unless the last step waits for the output.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ANGLE,
    OP_SQ,
    OP_P7,
    OP_P5,
    OP_P3,
    OP_P1,
    OP_MAG,
    OP_ACC,
    OP_ROUND,
    OP_GREEN,
    OP_SCALE,
    OP_DIV,
    OP_BRIGHT
  } op_t;

  typedef struct packed {
    logic [6:0] intensity;
    logic [3:0] speed;
    logic       enable;
    logic       pause;
  } cfg_t;

  typedef struct packed {
    logic       step;   // input transfer this cycle
    op_t        op;
    logic [1:0] harm;   // harmonic in work
  } cmd_t;

  typedef struct packed {
    logic frame_go;     // the offered item makes a frame
  } stat_t;

  function automatic logic [31:0] angle_k(input logic [1:0] harm);
    logic [31:0] k;
    case (harm)
      2'd0:    k = ANGLE_K1;
      2'd1:    k = ANGLE_K23;
      default: k = ANGLE_K47;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] harm_weight(input logic [1:0] harm);
    logic [31:0] w;
    case (harm)
      2'd0:    w = WEIGHT_1;
      2'd1:    w = WEIGHT_23;
      default: w = WEIGHT_47;
    endcase
    return w;
  endfunction

endpackage

/* hdl/ffg_cfg.sv */
// ----------------------------------------------------------------------------
// ffg_cfg
// Configuration register file of the fire flicker generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffg_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [6:0]    cfg_data,
  output ffg_pkg::cfg_t cfg
);
  import ffg_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.intensity <= INTENSITY_RST;
      cfg_r.speed     <= SPEED_RST;
      cfg_r.enable    <= 1'b0;
      cfg_r.pause     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INTENSITY: cfg_r.intensity <= cfg_data;
        REG_SPEED:     cfg_r.speed     <= cfg_data[3:0];
        REG_ENABLE:    cfg_r.enable    <= cfg_data[0];
        REG_PAUSE:     cfg_r.pause     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/ffg_ctrl.sv */
// ----------------------------------------------------------------------------
// ffg_ctrl
// Sequencer that steps the shared multiplier datapath through one frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  ffg_pkg::stat_t stat,
  output ffg_pkg::cmd_t  cmd
);
  import ffg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_SQ,
    ST_P7,
    ST_P5,
    ST_P3,
    ST_P1,
    ST_MAG,
    ST_ACC,
    ST_ROUND,
    ST_GREEN,
    ST_SCALE,
    ST_DIV,
    ST_BRIGHT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] harm_r, harm_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    harm_nxt      = harm_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd.step      = 1'b0;
    cmd.op        = OP_IDLE;
    cmd.harm      = harm_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.step = in_valid;
        if (in_valid && stat.frame_go) begin
          state_nxt = ST_ANGLE;
          harm_nxt  = 2'd0;
        end
      end
      ST_ANGLE: begin
        cmd.op    = OP_ANGLE;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = ST_P7;
      end
      ST_P7: begin
        cmd.op    = OP_P7;
        state_nxt = ST_P5;
      end
      ST_P5: begin
        cmd.op    = OP_P5;
        state_nxt = ST_P3;
      end
      ST_P3: begin
        cmd.op    = OP_P3;
        state_nxt = ST_P1;
      end
      ST_P1: begin
        cmd.op    = OP_P1;
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op = OP_ACC;
        if (harm_r == HARM_LAST) begin
          state_nxt = ST_ROUND;
        end else begin
          harm_nxt  = harm_r + 2'd1;
          state_nxt = ST_ANGLE;
        end
      end
      ST_ROUND: begin
        cmd.op    = OP_ROUND;
        state_nxt = ST_GREEN;
      end
      ST_GREEN: begin
        cmd.op    = OP_GREEN;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.op    = OP_SCALE;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op    = OP_DIV;
        state_nxt = ST_BRIGHT;
      end
      ST_BRIGHT: begin
        // The last step writes the output register, so it waits for a free slot.
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_BRIGHT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      harm_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      harm_r      <= harm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/ffg_dp.sv */
// ----------------------------------------------------------------------------
// ffg_dp
// Datapath: timing state, phase, one shared 32x32 multiplier and the
// registers of the sine, flicker, green and brightness computation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffg_dp #(
  parameter int unsigned FRAME_MS        = ffg_pkg::FRAME_MS_DEF,
  parameter int unsigned SINE_TABLE_BITS = ffg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ffg_pkg::cfg_t  cfg,
  input  ffg_pkg::cmd_t  cmd,
  output ffg_pkg::stat_t stat,
  input  logic [31:0]    in_now_ms,
  input  logic           in_restart,
  output logic [7:0]     out_green,
  output logic [6:0]     out_brightness
);
  import ffg_pkg::*;

  localparam int unsigned NB = SINE_TABLE_BITS;

  logic [47:0] phase_r;
  logic [31:0] last_r;
  logic        seen_r;

  logic [31:0] t_r;
  logic [31:0] x2_r;
  logic [31:0] p_r;
  logic [16:0] s_mag_r;
  logic        s_neg_r;
  logic signed [33:0] acc_r;
  logic [16:0] f_mag_r;
  logic        f_neg_r;
  logic [7:0]  green_r;
  logic [22:0] v_r;
  logic [15:0] q_r;
  logic [7:0]  out_green_r;
  logic [6:0]  out_bright_r;

  logic [3:0]  spd_c;
  logic [6:0]  inten_c;
  logic [31:0] elapsed;
  logic        restart_go;

  logic [NB-1:0] idx;
  logic [1:0]    quad;
  logic [NB-2:0] q_m;
  logic [30:0]   x_w;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [33:0] acc_mag;
  logic [33:0] acc_rnd;
  logic [17:0] cm_sum;
  logic [16:0] b_sum;
  logic [16:0] b_c;
  logic [31:0] mag_rnd;

  assign out_green      = out_green_r;
  assign out_brightness = out_bright_r;

  // Register clamps.
  always_comb begin
    spd_c = cfg.speed;
    if (cfg.speed < SPEED_MIN) spd_c = SPEED_MIN;
    if (cfg.speed > SPEED_MAX) spd_c = SPEED_MAX;
    inten_c = (cfg.intensity > INTENSITY_MAX) ? INTENSITY_MAX : cfg.intensity;
  end

  // Frame decision for the offered item.
  assign elapsed       = in_now_ms - last_r;
  assign restart_go    = in_restart || (cfg.enable && !seen_r);
  assign stat.frame_go = cfg.enable && seen_r && !cfg.pause && !in_restart &&
                         (elapsed >= 32'(FRAME_MS));

  // Quarter-wave folding of the table index taken from the turn fraction.
  always_comb begin
    idx  = t_r[31 -: NB];
    quad = idx[NB-1 -: 2];
    if (quad[0]) begin
      q_m = ((NB-1)'(1) << (NB-2)) - {1'b0, idx[NB-3:0]};
    end else begin
      q_m = {1'b0, idx[NB-3:0]};
    end
    x_w = {q_m, {(32-NB){1'b0}}};
  end

  // Operand selection of the shared multiplier.
  always_comb begin
    b_sum = f_neg_r ? (FACTOR_HALF - {1'b0, q_r}) : (FACTOR_HALF + {1'b0, q_r});
    b_c   = b_sum;
    if (b_sum < FACTOR_MIN) b_c = FACTOR_MIN;
    if (b_sum > FACTOR_MAX) b_c = FACTOR_MAX;
    cm_sum = f_neg_r ? (18'd65536 - {1'b0, f_mag_r}) : (18'd65536 + {1'b0, f_mag_r});
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (cmd.op)
      OP_ANGLE: begin
        mul_a = phase_r[31:0];
        mul_b = angle_k(cmd.harm);
      end
      OP_SQ: begin
        mul_a = {1'b0, x_w};
        mul_b = {1'b0, x_w};
      end
      OP_P7: begin
        mul_a = x2_r;
        mul_b = SIN_A9;
      end
      OP_P5, OP_P3, OP_P1: begin
        mul_a = x2_r;
        mul_b = p_r;
      end
      OP_MAG: begin
        mul_a = {1'b0, x_w};
        mul_b = p_r;
      end
      OP_ACC: begin
        mul_a = {15'd0, s_mag_r};
        mul_b = harm_weight(cmd.harm);
      end
      OP_GREEN: begin
        mul_a = {15'd0, cm_sum[17:1]};
        mul_b = GREEN_SCALE;
      end
      OP_SCALE: begin
        mul_a = {15'd0, f_mag_r};
        mul_b = {25'd0, inten_c};
      end
      OP_DIV: begin
        mul_a = {9'd0, v_r};
        mul_b = RECIP_200;
      end
      OP_BRIGHT: begin
        mul_a = {15'd0, b_c};
        mul_b = BRIGHT_SCALE;
      end
      default: ;
    endcase
  end

  assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
  assign mag_rnd = prod[61:30] + 32'd8192;

  // Rounding of the weighted sum, halves away from zero.
  assign acc_mag = acc_r[33] ? 34'(-acc_r) : 34'(acc_r);
  assign acc_rnd = acc_mag + 34'd32768;

  // Timing state and phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 48'd0;
      last_r  <= 32'd0;
      seen_r  <= 1'b0;
    end else begin
      if (!cfg.enable) begin
        seen_r <= 1'b0;
      end else if (cmd.step) begin
        seen_r <= 1'b1;
      end
      if (cmd.step) begin
        if (restart_go) begin
          phase_r <= 48'd0;
          last_r  <= in_now_ms;
        end else if (stat.frame_go) begin
          phase_r <= phase_r + 48'(spd_c);
          last_r  <= in_now_ms;
        end
      end
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      acc_r <= '0;
    end
    unique case (cmd.op)
      OP_ANGLE: t_r  <= prod[31:0];
      OP_SQ:    x2_r <= prod[61:30];
      OP_P7:    p_r  <= SIN_A7 - prod[61:30];
      OP_P5:    p_r  <= SIN_A5 - prod[61:30];
      OP_P3:    p_r  <= SIN_A3 - prod[61:30];
      OP_P1:    p_r  <= SIN_A1 - prod[61:30];
      OP_MAG: begin
        s_mag_r <= mag_rnd[30:14];
        s_neg_r <= quad[1];
      end
      OP_ACC: begin
        if (s_neg_r) begin
          acc_r <= acc_r - $signed({2'b00, prod[31:0]});
        end else begin
          acc_r <= acc_r + $signed({2'b00, prod[31:0]});
        end
      end
      OP_ROUND: begin
        f_neg_r <= acc_r[33];
        if (acc_rnd[33:16] > {1'b0, FLICKER_MAX}) begin
          f_mag_r <= FLICKER_MAX;
        end else begin
          f_mag_r <= acc_rnd[32:16];
        end
      end
      OP_GREEN: green_r <= GREEN_BASE + {1'b0, prod[22:16]};
      OP_SCALE: v_r     <= prod[22:0];
      OP_DIV:   q_r     <= prod[47:32];
      OP_BRIGHT: begin
        out_green_r  <= green_r;
        out_bright_r <= prod[22:16];
      end
      default: ;
    endcase
  end

endmodule

/* hdl/led_fire_flicker_generator.sv */
// ----------------------------------------------------------------------------
// led_fire_flicker_generator
// Fire flicker frame generator: turns millisecond timestamps into
// red/green/blue and brightness frames for an LED lamp.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   in_now_ms[31:0], in_restart
//   out_     output     out_valid / out_stall out_red, out_green, out_blue,
//                                             out_brightness
//   cfg_     input      cfg_valid / cfg_ready cfg_index[1:0], cfg_data[6:0]
//
// An item that makes no frame is taken and the next one can follow right
// away. An item that makes a frame keeps the input stalled while the frame
// is computed: each of the three harmonics takes eight steps of the one
// shared 32x32 multiplier, and five more steps form flicker, green and
// brightness. The frame then sits in the output register while new items
// are taken. The last step waits while a previous frame is still stalled.
// Reset is synchronous and active low; cfg_ready is always high.
//
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_fire_flicker_generator #(
  parameter int unsigned FRAME_MS        = ffg_pkg::FRAME_MS_DEF,
  parameter int unsigned SINE_TABLE_BITS = ffg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_now_ms,
  input  logic        in_restart,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic        out_blue,
  output logic [6:0]  out_brightness,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import ffg_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Red is always full and blue always off for the fire palette.
  assign out_red  = RED_LEVEL;
  assign out_blue = BLUE_LEVEL;

  // Register file: intensity, speed, enable and pause.
  ffg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The sequencer owns both handshakes; it accepts an item only when idle
  // and raises out_valid once the frame has been written.
  ffg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath decides whether an offered item makes a frame, keeps the
  // phase and the last frame time, and runs the fixed-point arithmetic.
  ffg_dp #(
    .FRAME_MS        (FRAME_MS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .in_now_ms      (in_now_ms),
    .in_restart     (in_restart),
    .out_green      (out_green),
    .out_brightness (out_brightness)
  );

endmodule

/* hdl/ffg_checker.sv */
// ----------------------------------------------------------------------------
// ffg_checker
// Port-level assertions of the fire flicker generator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic       out_blue,
  input logic [6:0] out_brightness
);

  // A stalled frame stays offered and unchanged.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_green) && $stable(out_brightness), "stalled frame dropped or changed")

  // Every frame lies in the fire palette and the brightness window.
  `ASSERT_CLK(a_out_range, clk, rst_n, out_valid |-> out_red == 8'd255 && out_blue == 1'b0 && out_green >= 8'd80 && out_green <= 8'd180 && out_brightness >= 7'd21 && out_brightness <= 7'd70, "frame out of range")

  // A new frame only appears after the block was busy computing it.
  `ASSERT_CLK(a_frame_busy, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "frame without computation")

  // Reset empties the output register.
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "frame present after reset")

endmodule

bind led_fire_flicker_generator ffg_checker u_ffg_checker (.*);
